@@ rtl/nesm_pkg.sv @@
// Shared types and constants for the next even smooth multiple block.
package nesm_pkg;

    localparam int STATUS_WIDTH = 2;

    localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_DIV_ZERO = 2'd2;

    // Odd factors taken out of the divisor by exact division.
    localparam logic [3:0] FACTOR_THREE = 4'd3;
    localparam logic [3:0] FACTOR_FIVE  = 4'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_STRIP2,
        S_DIV_START,
        S_DIV_WAIT,
        S_CHECK,
        S_SEARCH,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RES_TWO,
        RES_DIV_ZERO,
        RES_OVERFLOW,
        RES_SEARCH
    } res_t;

    typedef struct packed {
        logic load_item;
        logic shift2;
        logic div_start;
        logic div_take;
        logic sel_five;
        logic search_init;
        logic search_step;
        logic out_load;
        res_t res;
    } cmd_t;

    typedef struct packed {
        logic at_most_two;
        logic b_zero;
        logic lo_over;
        logic b_even;
        logic div_done;
        logic rem_zero;
        logic five;
        logic b_is_one;
        logic step_more;
    } sts_t;

endpackage

@@ rtl/nesm_req_if.sv @@
// Request channel: target and divisor with a valid/ready handshake.
interface nesm_req_if #(
    parameter int VALUE_WIDTH   = 32,
    parameter int DIVISOR_WIDTH = 12
);
    logic                            valid;
    logic                            ready;
    logic signed [VALUE_WIDTH-1:0]   target;
    logic        [DIVISOR_WIDTH-1:0] divisor;

    modport source (output valid, output target, output divisor, input ready);
    modport sink   (input valid, input target, input divisor, output ready);
endinterface

@@ rtl/nesm_rsp_if.sv @@
// Response channel: smooth value and status with a valid/ready handshake.
interface nesm_rsp_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-2:0] smooth_value;
    logic [1:0]             status;

    modport source (output valid, output smooth_value, output status, input ready);
    modport sink   (input valid, input smooth_value, input status, output ready);
endinterface

@@ rtl/nesm_div_const.sv @@
// Exact division by the constant three or five through multiplication by the modular inverse.
module nesm_div_const #(
    parameter int DIVISOR_WIDTH = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     five,
    input  logic [DIVISOR_WIDTH-1:0] dividend,
    output logic                     done,
    output logic                     rem_zero,
    output logic [DIVISOR_WIDTH-1:0] quotient
);

    // Inverse of an odd constant modulo 2^64; every round doubles the correct low bits.
    function automatic logic [63:0] inverse_of(input logic [63:0] d);
        logic [63:0] x;
        x = d;
        for (int n = 0; n < 6; n++)
        begin
            x = x * (64'd2 - d * x);
        end
        return x;
    endfunction

    localparam logic [63:0] WORD_MASK = (64'd1 << DIVISOR_WIDTH) - 64'd1;
    localparam logic [DIVISOR_WIDTH-1:0] INV_THREE =
        DIVISOR_WIDTH'(inverse_of(64'(nesm_pkg::FACTOR_THREE)));
    localparam logic [DIVISOR_WIDTH-1:0] INV_FIVE =
        DIVISOR_WIDTH'(inverse_of(64'(nesm_pkg::FACTOR_FIVE)));
    localparam logic [DIVISOR_WIDTH-1:0] MAX_Q_THREE =
        DIVISOR_WIDTH'(WORD_MASK / 64'(nesm_pkg::FACTOR_THREE));
    localparam logic [DIVISOR_WIDTH-1:0] MAX_Q_FIVE =
        DIVISOR_WIDTH'(WORD_MASK / 64'(nesm_pkg::FACTOR_FIVE));

    logic [DIVISOR_WIDTH-1:0] quo_reg, quo_next;
    logic                     zero_reg, zero_next;
    logic                     done_reg;
    logic [DIVISOR_WIDTH-1:0] inverse;
    logic [DIVISOR_WIDTH-1:0] limit;
    logic [DIVISOR_WIDTH-1:0] product;

    // For a multiple of the factor the product is the exact quotient; for
    // anything else it lands above the largest quotient a word can have.
    assign inverse = five ? INV_FIVE : INV_THREE;
    assign limit   = five ? MAX_Q_FIVE : MAX_Q_THREE;
    assign product = dividend * inverse;

    always_comb
    begin
        quo_next  = quo_reg;
        zero_next = zero_reg;
        if (start)
        begin
            quo_next  = product;
            zero_next = (product <= limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        zero_reg <= zero_next;
    end

    assign done     = done_reg;
    assign rem_zero = zero_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/nesm_datapath.sv @@
// Datapath: divisor factoring, smooth candidate walk, best match and result register.
module nesm_datapath #(
    parameter int VALUE_WIDTH   = 32,
    parameter int DIVISOR_WIDTH = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  nesm_pkg::cmd_t                   cmd,
    output nesm_pkg::sts_t                   sts,
    input  logic signed [VALUE_WIDTH-1:0]    target,
    input  logic        [DIVISOR_WIDTH-1:0]  divisor,
    output logic        [VALUE_WIDTH-2:0]    smooth_value,
    output logic        [nesm_pkg::STATUS_WIDTH-1:0] status
);

    localparam int CW    = VALUE_WIDTH - 1;
    localparam int EXP_W = $clog2(VALUE_WIDTH + DIVISOR_WIDTH);
    localparam logic [CW+2:0] MAXV = {3'b000, {CW{1'b1}}};

    logic [VALUE_WIDTH-1:0]   lo_reg, lo_next;
    logic                     small_reg, small_next;
    logic [DIVISOR_WIDTH-1:0] b_reg, b_next;
    logic [EXP_W-1:0]         e2_reg, e2_next, e3_reg, e3_next, e5_reg, e5_next;
    logic                     five_reg, five_next;
    logic [CW-1:0]            a_reg, a_next, m_reg, m_next, c_reg, c_next;
    logic [EXP_W-1:0]         i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CW-1:0]            best_reg, best_next;
    logic                     found_reg, found_next;
    logic [CW-1:0]            value_reg, value_next;
    logic [nesm_pkg::STATUS_WIDTH-1:0] status_reg, status_next;

    logic                     div_done;
    logic                     rem_zero;
    logic [DIVISOR_WIDTH-1:0] quotient;

    logic [CW+2:0] c5;
    logic [CW+1:0] m3;
    logic [CW:0]   a2;
    logic          ok5, ok3, ok2;
    logic          hit;

    nesm_div_const #(
        .DIVISOR_WIDTH (DIVISOR_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .five     (five_reg),
        .dividend (b_reg),
        .done     (div_done),
        .rem_zero (rem_zero),
        .quotient (quotient)
    );

    assign c5  = {1'b0, c_reg, 2'b00} + {3'b000, c_reg};
    assign m3  = {1'b0, m_reg, 1'b0} + {2'b00, m_reg};
    assign a2  = {a_reg, 1'b0};
    assign ok5 = (c5 <= MAXV);
    assign ok3 = (m3 <= MAXV[CW+1:0]);
    assign ok2 = (a2 <= MAXV[CW:0]);

    // A candidate 2^i 3^j 5^k is a multiple of the divisor when every exponent
    // covers that of the divisor and nothing else is left of the divisor.
    assign hit = ({1'b0, c_reg} >= lo_reg) && (i_reg >= e2_reg) && (j_reg >= e3_reg)
               && (k_reg >= e5_reg) && (!found_reg || (c_reg < best_reg));

    always_comb
    begin
        lo_next     = lo_reg;
        small_next  = small_reg;
        b_next      = b_reg;
        e2_next     = e2_reg;
        e3_next     = e3_reg;
        e5_next     = e5_reg;
        five_next   = five_reg;
        a_next      = a_reg;
        m_next      = m_reg;
        c_next      = c_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        value_next  = value_reg;
        status_next = status_reg;

        if (cmd.load_item)
        begin
            // Anything at or below two, negatives included, answers two.
            small_next = target[VALUE_WIDTH-1]
                       || ((target[VALUE_WIDTH-2:2] == '0) && (target[1:0] != 2'b11));
            lo_next    = $unsigned(target)
                       + {{(VALUE_WIDTH-1){1'b0}}, target[0]};
            b_next     = divisor;
            e2_next    = '0;
            e3_next    = '0;
            e5_next    = '0;
            five_next  = 1'b0;
        end

        if (cmd.shift2)
        begin
            b_next  = {1'b0, b_reg[DIVISOR_WIDTH-1:1]};
            e2_next = e2_reg + EXP_W'(1);
        end

        if (cmd.div_take)
        begin
            b_next = quotient;
            if (five_reg)
            begin
                e5_next = e5_reg + EXP_W'(1);
            end
            else
            begin
                e3_next = e3_reg + EXP_W'(1);
            end
        end

        if (cmd.sel_five)
        begin
            five_next = 1'b1;
        end

        if (cmd.search_init)
        begin
            a_next     = CW'(2);
            m_next     = CW'(2);
            c_next     = CW'(2);
            i_next     = EXP_W'(1);
            j_next     = '0;
            k_next     = '0;
            found_next = 1'b0;
        end

        if (cmd.search_step)
        begin
            if (hit)
            begin
                best_next  = c_reg;
                found_next = 1'b1;
            end
            if (ok5)
            begin
                c_next = c5[CW-1:0];
                k_next = k_reg + EXP_W'(1);
            end
            else if (ok3)
            begin
                m_next = m3[CW-1:0];
                c_next = m3[CW-1:0];
                j_next = j_reg + EXP_W'(1);
                k_next = '0;
            end
            else if (ok2)
            begin
                a_next = a2[CW-1:0];
                m_next = a2[CW-1:0];
                c_next = a2[CW-1:0];
                i_next = i_reg + EXP_W'(1);
                j_next = '0;
                k_next = '0;
            end
        end

        if (cmd.out_load)
        begin
            case (cmd.res)
                nesm_pkg::RES_TWO:
                begin
                    value_next  = CW'(2);
                    status_next = nesm_pkg::ST_OK;
                end
                nesm_pkg::RES_DIV_ZERO:
                begin
                    value_next  = '0;
                    status_next = nesm_pkg::ST_DIV_ZERO;
                end
                nesm_pkg::RES_SEARCH:
                begin
                    value_next  = found_reg ? best_reg : '0;
                    status_next = found_reg ? nesm_pkg::ST_OK : nesm_pkg::ST_OVERFLOW;
                end
                default:
                begin
                    value_next  = '0;
                    status_next = nesm_pkg::ST_OVERFLOW;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        small_reg  <= small_next;
        b_reg      <= b_next;
        e2_reg     <= e2_next;
        e3_reg     <= e3_next;
        e5_reg     <= e5_next;
        five_reg   <= five_next;
        a_reg      <= a_next;
        m_reg      <= m_next;
        c_reg      <= c_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        best_reg   <= best_next;
        found_reg  <= found_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        sts.at_most_two = small_reg;
        sts.b_zero      = (b_reg == '0);
        sts.lo_over     = lo_reg[VALUE_WIDTH-1];
        sts.b_even      = !b_reg[0];
        sts.div_done    = div_done;
        sts.rem_zero    = rem_zero;
        sts.five        = five_reg;
        sts.b_is_one    = (b_reg == DIVISOR_WIDTH'(1));
        sts.step_more   = ok5 || ok3 || ok2;
    end

    assign smooth_value = value_reg;
    assign status       = status_reg;

endmodule

@@ rtl/nesm_ctrl.sv @@
// Controller state machine: sequences classification, factoring, search and the response.
module nesm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  nesm_pkg::sts_t sts,
    output nesm_pkg::cmd_t cmd
);

    nesm_pkg::state_t state_reg, state_next;
    nesm_pkg::res_t   res_reg, res_next;
    logic             valid_reg, valid_next;
    logic             slot_free;

    assign slot_free = !valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        unique case (state_reg)
            nesm_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = nesm_pkg::S_CLASSIFY;
                end
            end
            nesm_pkg::S_CLASSIFY:
            begin
                if (sts.at_most_two)
                begin
                    res_next   = nesm_pkg::RES_TWO;
                    state_next = nesm_pkg::S_DONE;
                end
                else if (sts.b_zero)
                begin
                    res_next   = nesm_pkg::RES_DIV_ZERO;
                    state_next = nesm_pkg::S_DONE;
                end
                else if (sts.lo_over)
                begin
                    res_next   = nesm_pkg::RES_OVERFLOW;
                    state_next = nesm_pkg::S_DONE;
                end
                else
                begin
                    state_next = nesm_pkg::S_STRIP2;
                end
            end
            nesm_pkg::S_STRIP2:
            begin
                if (!sts.b_even)
                begin
                    state_next = nesm_pkg::S_DIV_START;
                end
            end
            nesm_pkg::S_DIV_START:
            begin
                state_next = nesm_pkg::S_DIV_WAIT;
            end
            nesm_pkg::S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    if (sts.rem_zero || !sts.five)
                    begin
                        state_next = nesm_pkg::S_DIV_START;
                    end
                    else
                    begin
                        state_next = nesm_pkg::S_CHECK;
                    end
                end
            end
            nesm_pkg::S_CHECK:
            begin
                // A divisor with any other prime factor has no smooth multiple.
                if (sts.b_is_one)
                begin
                    state_next = nesm_pkg::S_SEARCH;
                end
                else
                begin
                    res_next   = nesm_pkg::RES_OVERFLOW;
                    state_next = nesm_pkg::S_DONE;
                end
            end
            nesm_pkg::S_SEARCH:
            begin
                if (!sts.step_more)
                begin
                    res_next   = nesm_pkg::RES_SEARCH;
                    state_next = nesm_pkg::S_DONE;
                end
            end
            nesm_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = nesm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nesm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.res   = res_reg;
        req_ready = 1'b0;
        unique case (state_reg)
            nesm_pkg::S_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.load_item = req_valid;
            end
            nesm_pkg::S_STRIP2:
            begin
                cmd.shift2 = sts.b_even;
            end
            nesm_pkg::S_DIV_START:
            begin
                cmd.div_start = 1'b1;
            end
            nesm_pkg::S_DIV_WAIT:
            begin
                cmd.div_take = sts.div_done && sts.rem_zero;
                cmd.sel_five = sts.div_done && !sts.rem_zero && !sts.five;
            end
            nesm_pkg::S_CHECK:
            begin
                cmd.search_init = sts.b_is_one;
            end
            nesm_pkg::S_SEARCH:
            begin
                cmd.search_step = 1'b1;
            end
            nesm_pkg::S_DONE:
            begin
                cmd.out_load = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nesm_pkg::S_IDLE;
            res_reg   <= nesm_pkg::RES_TWO;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
            valid_reg <= valid_next;
        end
    end

    assign rsp_valid = valid_reg;

endmodule

@@ rtl/next_even_smooth_multiple.sv @@
// Finds the smallest even multiple of a divisor, at least a target, with no
// prime factor above five. One request is worked on at a time. A request is
// first loaded and then classified; targets of two or less, a zero divisor or a
// target beyond range finish there. Otherwise the divisor is factored: factors
// of two are shifted out one at a time, with one more step to find it odd; then
// each exact division by three or five takes a start and a wait state (one more
// trial than there are factors, for each of the two), and a check sees whether
// anything else is left of it. The search then walks every even 5-smooth number
// up to 2^(VALUE_WIDTH-1) - 1, one a cycle, and this walk sets the overall time.
// The result waits in an output register, and a new request is taken while it
// waits.
module next_even_smooth_multiple #(
    parameter int VALUE_WIDTH   = 32,
    parameter int DIVISOR_WIDTH = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    nesm_req_if.sink    request,
    nesm_rsp_if.source  response
);

    nesm_pkg::cmd_t cmd;
    nesm_pkg::sts_t sts;

    nesm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .rsp_valid (response.valid),
        .rsp_ready (response.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    nesm_datapath #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .DIVISOR_WIDTH (DIVISOR_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .target       (request.target),
        .divisor      (request.divisor),
        .smooth_value (response.smooth_value),
        .status       (response.status)
    );

endmodule
